// ===== rtl/nearest_hits_keeper_assert.svh =====
// Assertion macros for the nearest hits keeper.
// Takes no other file; used by the modules that carry assertions.
`ifndef NEAREST_HITS_KEEPER_ASSERT_SVH
`define NEAREST_HITS_KEEPER_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define NHK_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nearest_hits_keeper assertion failed");

// Next-cycle implication, disabled in reset
`define NHK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nearest_hits_keeper assertion failed");

`endif

// ===== rtl/nhk_pkg.sv =====
// Shared types and constants for the nearest hits keeper.
// No dependencies; used by the interfaces and the keeper module.
package nhk_pkg;

    // Storage size and derived widths
    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // Payload field widths
    localparam int MODE_W = 2;
    localparam int FRAC_W = 17;
    localparam int BODY_W = 16;
    localparam int TRI_W  = 32;
    localparam int RSLOT_W = 4;
    localparam int HCNT_W = 5;

    localparam logic [FRAC_W-1:0] ONE_FRAC = FRAC_W'(65536);

    // Item modes
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HIT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSEST_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HITS     = 1'b1;

    // One stored hit
    typedef struct packed {
        logic [FRAC_W-1:0] frac;
        logic [BODY_W-1:0] body;
        logic [TRI_W-1:0]  tri_idx;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_REPLACE,
        ST_RDWAIT,
        ST_POST
    } state_t;

    // What a scan is for
    typedef enum logic {
        SCAN_VICTIM,
        SCAN_CUTOFF
    } scan_kind_t;

endpackage

// ===== rtl/nhk_ifs.sv =====
// Valid/ready channel interfaces for hit items and result items.
// Depends on nhk_pkg for field widths.
interface nhk_hit_if;
    logic                            valid;
    logic                            ready;
    logic [nhk_pkg::MODE_W-1:0]      mode;
    logic [nhk_pkg::FRAC_W-1:0]      hit_fraction;
    logic [nhk_pkg::BODY_W-1:0]      body_id;
    logic [nhk_pkg::TRI_W-1:0]       triangle_index;
    logic [nhk_pkg::RSLOT_W-1:0]     read_slot;

    modport source (output valid, mode, hit_fraction, body_id, triangle_index, read_slot,
                    input ready);
    modport sink   (input valid, mode, hit_fraction, body_id, triangle_index, read_slot,
                    output ready);
endinterface

interface nhk_result_if;
    logic                            valid;
    logic                            ready;
    logic                            accepted;
    logic [nhk_pkg::RSLOT_W-1:0]     slot_used;
    logic [nhk_pkg::FRAC_W-1:0]      cutoff;
    logic [nhk_pkg::HCNT_W-1:0]      hit_count;
    logic [nhk_pkg::FRAC_W-1:0]      slot_fraction;
    logic [nhk_pkg::BODY_W-1:0]      slot_body;
    logic [nhk_pkg::TRI_W-1:0]       slot_triangle;

    modport source (output valid, accepted, slot_used, cutoff, hit_count, slot_fraction,
                    slot_body, slot_triangle, input ready);
    modport sink   (input valid, accepted, slot_used, cutoff, hit_count, slot_fraction,
                    slot_body, slot_triangle, output ready);
endinterface

// ===== rtl/nhk_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module nhk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/nearest_hits_keeper.sv =====
// One transaction at a time, taken again in the cycle after the result is loaded into the output
// register (where it may wait). A read waits on the registered RAM port. A hit that fills the
// set in closest mode scans for the new cutoff; a replacement scans for the furthest hit,
// overwrites it, then rescans for the new cutoff. Each scan runs the shared comparator over the
// stored fractions (one registered RAM read per cycle).
// Reset (async, active low): set empty, cutoff 1.0, closest mode, max_hits 16.
`include "nearest_hits_keeper_assert.svh"

module nearest_hits_keeper (
    input  logic                             clk,
    input  logic                             rst_n,
    nhk_hit_if.sink                          hit_req,
    nhk_result_if.source                     hit_rsp,
    input  logic                             cfg_we,
    input  logic [nhk_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nhk_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int SW = nhk_pkg::SLOT_W;
    localparam int CW = nhk_pkg::CNT_W;
    localparam int FW = nhk_pkg::FRAC_W;

    // Control state
    nhk_pkg::state_t      state_reg, state_next;
    nhk_pkg::scan_kind_t  scan_kind_reg, scan_kind_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [FW-1:0]        cutoff_reg, cutoff_next;
    logic [CW-1:0]        scan_cnt_reg, scan_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 closest_reg;
    logic [nhk_pkg::CFG_DATA_W-1:0] max_hits_reg;

    // Latched transaction
    logic [nhk_pkg::MODE_W-1:0]  op_mode_reg, op_mode_next;
    logic [FW-1:0]               op_frac_reg, op_frac_next;
    logic [nhk_pkg::BODY_W-1:0]  op_body_reg, op_body_next;
    logic [nhk_pkg::TRI_W-1:0]   op_tri_reg, op_tri_next;
    logic [nhk_pkg::RSLOT_W-1:0] op_slot_reg, op_slot_next;

    // Scan and result working registers
    logic [FW-1:0]  best_frac_reg, best_frac_next;
    logic [SW-1:0]  best_idx_reg, best_idx_next;
    logic           res_acc_reg, res_acc_next;
    logic [SW-1:0]  res_used_reg, res_used_next;
    nhk_pkg::entry_t res_entry_reg, res_entry_next;

    // Output register
    logic                         out_acc_reg, out_acc_next;
    logic [SW-1:0]                out_used_reg, out_used_next;
    logic [FW-1:0]                out_cutoff_reg, out_cutoff_next;
    logic [CW-1:0]                out_count_reg, out_count_next;
    nhk_pkg::entry_t              out_entry_reg, out_entry_next;

    // RAM port signals
    logic            ram_we;
    logic [SW-1:0]   ram_waddr;
    nhk_pkg::entry_t ram_wdata;
    logic [SW-1:0]   ram_raddr;
    nhk_pkg::entry_t ram_rdata;

    logic [CW-1:0]   lim;
    logic            scan_take;
    logic [FW-1:0]   best_frac_scan;
    logic [SW-1:0]   best_idx_scan;

    nhk_ram #(
        .WIDTH (nhk_pkg::ENTRY_W),
        .DEPTH (nhk_pkg::SLOTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Capacity clamped to 1..SLOTS
    always_comb
    begin
        if (max_hits_reg == '0)
        begin
            lim = CW'(1);
        end
        else if (32'(max_hits_reg) > nhk_pkg::SLOTS)
        begin
            lim = CW'(nhk_pkg::SLOTS);
        end
        else
        begin
            lim = CW'(max_hits_reg);
        end
    end

    // Shared comparator: data read last cycle against the running maximum
    always_comb
    begin
        scan_take      = (scan_cnt_reg != '0) && (ram_rdata.frac > best_frac_reg);
        best_frac_scan = scan_take ? ram_rdata.frac : best_frac_reg;
        best_idx_scan  = scan_take ? SW'(scan_cnt_reg - CW'(1)) : best_idx_reg;
    end

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        scan_kind_next  = scan_kind_reg;
        count_next      = count_reg;
        cutoff_next     = cutoff_reg;
        scan_cnt_next   = scan_cnt_reg;
        op_mode_next    = op_mode_reg;
        op_frac_next    = op_frac_reg;
        op_body_next    = op_body_reg;
        op_tri_next     = op_tri_reg;
        op_slot_next    = op_slot_reg;
        best_frac_next  = best_frac_reg;
        best_idx_next   = best_idx_reg;
        res_acc_next    = res_acc_reg;
        res_used_next   = res_used_reg;
        res_entry_next  = res_entry_reg;
        out_acc_next    = out_acc_reg;
        out_used_next   = out_used_reg;
        out_cutoff_next = out_cutoff_reg;
        out_count_next  = out_count_reg;
        out_entry_next  = out_entry_reg;
        out_valid_next  = out_valid_reg && !hit_rsp.ready;

        ram_we            = 1'b0;
        ram_waddr         = count_reg[SW-1:0];
        ram_wdata.frac    = op_frac_reg;
        ram_wdata.body    = op_body_reg;
        ram_wdata.tri_idx = op_tri_reg;
        ram_raddr         = scan_cnt_reg[SW-1:0];

        hit_req.ready = (state_reg == nhk_pkg::ST_IDLE);

        case (state_reg)
            nhk_pkg::ST_IDLE:
            begin
                if (hit_req.valid)
                begin
                    op_mode_next   = hit_req.mode;
                    op_frac_next   = hit_req.hit_fraction;
                    op_body_next   = hit_req.body_id;
                    op_tri_next    = hit_req.triangle_index;
                    op_slot_next   = hit_req.read_slot;
                    res_acc_next   = 1'b0;
                    res_used_next  = '0;
                    res_entry_next = '0;
                    state_next     = nhk_pkg::ST_EXEC;
                end
            end

            nhk_pkg::ST_EXEC:
            begin
                state_next = nhk_pkg::ST_POST;
                case (op_mode_reg)
                    nhk_pkg::MODE_CLEAR:
                    begin
                        count_next  = '0;
                        cutoff_next = nhk_pkg::ONE_FRAC;
                    end
                    nhk_pkg::MODE_HIT:
                    begin
                        if (count_reg < lim)
                        begin
                            // Filling: append at the next free slot
                            ram_we        = 1'b1;
                            ram_waddr     = count_reg[SW-1:0];
                            count_next    = count_reg + CW'(1);
                            res_acc_next  = 1'b1;
                            res_used_next = count_reg[SW-1:0];
                            if (32'(count_reg) + 1 >= 32'(lim))
                            begin
                                if (closest_reg)
                                begin
                                    scan_kind_next = nhk_pkg::SCAN_CUTOFF;
                                    scan_cnt_next  = '0;
                                    best_frac_next = '0;
                                    best_idx_next  = '0;
                                    state_next     = nhk_pkg::ST_SCAN;
                                end
                                else
                                begin
                                    cutoff_next = '0;
                                end
                            end
                        end
                        else if (closest_reg && (op_frac_reg < cutoff_reg))
                        begin
                            // Full: find the furthest hit to evict
                            scan_kind_next = nhk_pkg::SCAN_VICTIM;
                            scan_cnt_next  = '0;
                            best_frac_next = '0;
                            best_idx_next  = '0;
                            state_next     = nhk_pkg::ST_SCAN;
                        end
                    end
                    nhk_pkg::MODE_READ:
                    begin
                        if (CW'(op_slot_reg) < count_reg)
                        begin
                            ram_raddr  = SW'(op_slot_reg);
                            state_next = nhk_pkg::ST_RDWAIT;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            nhk_pkg::ST_SCAN:
            begin
                ram_raddr      = scan_cnt_reg[SW-1:0];
                best_frac_next = best_frac_scan;
                best_idx_next  = best_idx_scan;
                if (scan_cnt_reg == count_reg)
                begin
                    if (scan_kind_reg == nhk_pkg::SCAN_VICTIM)
                    begin
                        state_next = nhk_pkg::ST_REPLACE;
                    end
                    else
                    begin
                        cutoff_next = best_frac_scan;
                        state_next  = nhk_pkg::ST_POST;
                    end
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + CW'(1);
                end
            end

            nhk_pkg::ST_REPLACE:
            begin
                // Overwrite the furthest hit, then rescan for the new cutoff
                ram_we         = 1'b1;
                ram_waddr      = best_idx_reg;
                res_acc_next   = 1'b1;
                res_used_next  = best_idx_reg;
                scan_kind_next = nhk_pkg::SCAN_CUTOFF;
                scan_cnt_next  = '0;
                best_frac_next = '0;
                best_idx_next  = '0;
                state_next     = nhk_pkg::ST_SCAN;
            end

            nhk_pkg::ST_RDWAIT:
            begin
                res_entry_next = ram_rdata;
                state_next     = nhk_pkg::ST_POST;
            end

            nhk_pkg::ST_POST:
            begin
                if (!out_valid_reg || hit_rsp.ready)
                begin
                    out_acc_next    = res_acc_reg;
                    out_used_next   = res_used_reg;
                    out_cutoff_next = cutoff_reg;
                    out_count_next  = count_reg;
                    out_entry_next  = res_entry_reg;
                    out_valid_next  = 1'b1;
                    state_next      = nhk_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = nhk_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nhk_pkg::ST_IDLE;
            scan_kind_reg <= nhk_pkg::SCAN_CUTOFF;
            count_reg     <= '0;
            cutoff_reg    <= nhk_pkg::ONE_FRAC;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_kind_reg <= scan_kind_next;
            count_reg     <= count_next;
            cutoff_reg    <= cutoff_next;
            scan_cnt_reg  <= scan_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closest_reg  <= 1'b1;
            max_hits_reg <= nhk_pkg::CFG_DATA_W'(16);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nhk_pkg::CFG_CLOSEST_MODE: closest_reg  <= cfg_data[0];
                nhk_pkg::CFG_MAX_HITS:     max_hits_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_mode_reg    <= op_mode_next;
        op_frac_reg    <= op_frac_next;
        op_body_reg    <= op_body_next;
        op_tri_reg     <= op_tri_next;
        op_slot_reg    <= op_slot_next;
        best_frac_reg  <= best_frac_next;
        best_idx_reg   <= best_idx_next;
        res_acc_reg    <= res_acc_next;
        res_used_reg   <= res_used_next;
        res_entry_reg  <= res_entry_next;
        out_acc_reg    <= out_acc_next;
        out_used_reg   <= out_used_next;
        out_cutoff_reg <= out_cutoff_next;
        out_count_reg  <= out_count_next;
        out_entry_reg  <= out_entry_next;
    end

    // Result channel
    assign hit_rsp.valid         = out_valid_reg;
    assign hit_rsp.accepted      = out_acc_reg;
    assign hit_rsp.slot_used     = nhk_pkg::RSLOT_W'(out_used_reg);
    assign hit_rsp.cutoff        = out_cutoff_reg;
    assign hit_rsp.hit_count     = nhk_pkg::HCNT_W'(out_count_reg);
    assign hit_rsp.slot_fraction = out_entry_reg.frac;
    assign hit_rsp.slot_body     = out_entry_reg.body;
    assign hit_rsp.slot_triangle = out_entry_reg.tri_idx;

    // Checks
    `NHK_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, (32'(count_reg) <= nhk_pkg::SLOTS))
    `NHK_ASSERT_NOW(a_scan_bound, clk, rst_n, (state_reg == nhk_pkg::ST_SCAN),
                    (scan_cnt_reg <= count_reg))
    `NHK_ASSERT_NOW(a_victim_stored, clk, rst_n, (state_reg == nhk_pkg::ST_REPLACE),
                    (CW'(best_idx_reg) < count_reg))
    `NHK_ASSERT_NOW(a_write_states, clk, rst_n, ram_we,
                    ((state_reg == nhk_pkg::ST_EXEC) || (state_reg == nhk_pkg::ST_REPLACE)))
    `NHK_ASSERT_NEXT(a_result_held, clk, rst_n, (out_valid_reg && !hit_rsp.ready),
                     out_valid_reg)

endmodule
